>>> hw/rtl/tsd_pkg.sv
// shared types and constants for the tar stream deframer
package tsd_pkg;

    localparam int unsigned BLOCK_W       = 9;
    localparam int unsigned SIZE_W        = 36;
    localparam int unsigned RES_FIFO_DEPTH = 4;

    localparam logic [BLOCK_W-1:0] BLOCK_LAST       = 9'd511;
    localparam logic [BLOCK_W-1:0] SIZE_FIELD_FIRST = 9'd124;
    localparam logic [BLOCK_W-1:0] SIZE_FIELD_LAST  = 9'd135;
    localparam logic [BLOCK_W-1:0] TYPE_OFFSET      = 9'd156;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_END    = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        END_ZERO_BLOCK = 2'd0,
        END_BETWEEN    = 2'd1,
        END_TRUNCATED  = 2'd2
    } t_end_status;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_DATA   = 4'b0010,
        PH_PAD    = 4'b0100,
        PH_DONE   = 4'b1000
    } t_phase;

    typedef struct packed {
        t_kind              kind;
        logic [7:0]         data_out;
        logic [SIZE_W-1:0]  entry_size;
        logic [7:0]         entry_type;
        logic               is_regular;
        logic               last_of_entry;
        t_end_status        end_status;
    } t_result;

    // results produced by one accepted word, packed toward slot 0
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

>>> hw/rtl/tsd_parser.sv
// header/data/padding parser: state update and result forming for one word
module tsd_parser
    import tsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_archive_byte,
    input  logic       i_stream_end,
    input  logic       i_extract_enable,
    output t_push      o_push
);

    t_phase              r_phase, n_phase;
    logic [BLOCK_W-1:0]  r_header_index, n_header_index;
    logic                r_all_zero, n_all_zero;
    logic [SIZE_W-1:0]   r_size_acc, n_size_acc;
    logic                r_size_stopped, n_size_stopped;
    logic [7:0]          r_type, n_type;
    logic [SIZE_W-1:0]   r_data_rem, n_data_rem;
    logic [BLOCK_W-1:0]  r_pad_rem, n_pad_rem;

    logic    type_regular;
    logic    data_last;
    logic    have_main;
    t_result main_res;
    t_result end_res;
    logic    have_end;

    assign type_regular = (r_type == CH_ZERO) || (r_type == CH_NUL);
    assign data_last    = (r_data_rem <= SIZE_W'(1));

    always_comb begin
        n_phase        = r_phase;
        n_header_index = r_header_index;
        n_all_zero     = r_all_zero;
        n_size_acc     = r_size_acc;
        n_size_stopped = r_size_stopped;
        n_type         = r_type;
        n_data_rem     = r_data_rem;
        n_pad_rem      = r_pad_rem;
        have_main      = 1'b0;
        main_res       = '0;
        have_end       = 1'b0;
        end_res        = '0;

        unique case (r_phase)
            PH_HEADER: begin
                if (i_archive_byte != 8'd0) begin
                    n_all_zero = 1'b0;
                end
                if (r_header_index >= SIZE_FIELD_FIRST && r_header_index <= SIZE_FIELD_LAST
                        && !r_size_stopped) begin
                    if (i_archive_byte == CH_NUL) begin
                        n_size_stopped = 1'b1;
                    end else if (i_archive_byte >= CH_ZERO && i_archive_byte <= CH_SEVEN) begin
                        // '0' has zero low bits, so the digit value is the low three bits
                        n_size_acc = {r_size_acc[SIZE_W-4:0], i_archive_byte[2:0]};
                    end
                end
                if (r_header_index == TYPE_OFFSET) begin
                    n_type = i_archive_byte;
                end
                if (r_header_index == BLOCK_LAST) begin
                    have_main = 1'b1;
                    if (r_all_zero && i_archive_byte == 8'd0) begin
                        main_res.kind       = KIND_END;
                        main_res.end_status = END_ZERO_BLOCK;
                        n_phase             = PH_DONE;
                    end else begin
                        main_res.kind       = KIND_HEADER;
                        main_res.entry_size = r_size_acc;
                        main_res.entry_type = r_type;
                        main_res.is_regular = type_regular;
                        n_data_rem          = r_size_acc;
                        // distance to the next block boundary
                        n_pad_rem           = BLOCK_W'(0) - r_size_acc[BLOCK_W-1:0];
                        n_phase             = (r_size_acc == '0) ? PH_HEADER : PH_DATA;
                    end
                    n_header_index = '0;
                    n_all_zero     = 1'b1;
                    n_size_acc     = '0;
                    n_size_stopped = 1'b0;
                end else begin
                    n_header_index = r_header_index + BLOCK_W'(1);
                end
            end
            PH_DATA: begin
                if (i_extract_enable && type_regular) begin
                    have_main              = 1'b1;
                    main_res.kind          = KIND_DATA;
                    main_res.data_out      = i_archive_byte;
                    main_res.is_regular    = 1'b1;
                    main_res.last_of_entry = data_last;
                end
                if (data_last) begin
                    n_data_rem = '0;
                    n_phase    = (r_pad_rem != '0) ? PH_PAD : PH_HEADER;
                end else begin
                    n_data_rem = r_data_rem - SIZE_W'(1);
                end
            end
            PH_PAD: begin
                if (r_pad_rem <= BLOCK_W'(1)) begin
                    n_pad_rem = '0;
                    n_phase   = PH_HEADER;
                end else begin
                    n_pad_rem = r_pad_rem - BLOCK_W'(1);
                end
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase

        if (i_stream_end) begin
            if (n_phase == PH_DATA) begin
                have_end           = 1'b1;
                end_res.kind       = KIND_END;
                end_res.end_status = END_TRUNCATED;
            end else if (n_phase != PH_DONE) begin
                have_end           = 1'b1;
                end_res.kind       = KIND_END;
                end_res.end_status = END_BETWEEN;
            end
            n_phase        = PH_HEADER;
            n_header_index = '0;
            n_all_zero     = 1'b1;
            n_size_acc     = '0;
            n_size_stopped = 1'b0;
            n_type         = '0;
            n_data_rem     = '0;
            n_pad_rem      = '0;
        end

        o_push = '0;
        if (i_accept) begin
            o_push.count = 2'(have_main) + 2'(have_end);
            o_push.res0  = have_main ? main_res : end_res;
            o_push.res1  = end_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HEADER;
            r_header_index <= '0;
            r_all_zero     <= 1'b1;
            r_size_acc     <= '0;
            r_size_stopped <= 1'b0;
            r_type         <= '0;
            r_data_rem     <= '0;
            r_pad_rem      <= '0;
        end else if (i_accept) begin
            r_phase        <= n_phase;
            r_header_index <= n_header_index;
            r_all_zero     <= n_all_zero;
            r_size_acc     <= n_size_acc;
            r_size_stopped <= n_size_stopped;
            r_type         <= n_type;
            r_data_rem     <= n_data_rem;
            r_pad_rem      <= n_pad_rem;
        end
    end

endmodule

>>> hw/rtl/tsd_result_fifo.sv
// small result queue taking up to two results a cycle and giving one per pop
module tsd_result_fifo
    import tsd_pkg::*;
#(
    parameter int unsigned DEPTH = RES_FIFO_DEPTH
)(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop,
    output logic    o_valid,
    output logic    o_full2,
    output t_result o_res
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(DEPTH - 2);

    t_result            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wptr, n_wptr;
    logic [PTR_W-1:0]   r_rptr, n_rptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [PTR_W-1:0]   wptr1;
    logic [PTR_W-1:0]   wptr2;
    logic               pop;

    assign wptr1 = (r_wptr == PTR_LAST) ? '0 : r_wptr + PTR_W'(1);
    assign wptr2 = (wptr1 == PTR_LAST) ? '0 : wptr1 + PTR_W'(1);
    assign pop   = i_pop && (r_count != '0);

    always_comb begin
        unique case (i_push.count)
            2'd0:    n_wptr = r_wptr;
            2'd1:    n_wptr = wptr1;
            default: n_wptr = wptr2;
        endcase
        n_rptr  = pop ? ((r_rptr == PTR_LAST) ? '0 : r_rptr + PTR_W'(1)) : r_rptr;
        n_count = r_count + CNT_W'(i_push.count) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wptr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wptr1] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    assign o_valid = (r_count != '0);
    // keep room for the two results one word may cause
    assign o_full2 = (r_count > ROOM_LIMIT);
    assign o_res   = r_mem[r_rptr];

endmodule

>>> hw/rtl/tar_stream_deframer.sv
// top level of the tar stream deframer
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------
//  in       | i_valid / o_stall    | i_archive_byte, i_stream_end
//  out      | o_valid / i_stall    | o_kind, o_data_out, o_entry_size, o_entry_type,
//           |                      | o_is_regular, o_last_of_entry, o_end_status
//  cfg      | i_cfg_wr_en          | i_cfg_wr_data (extract enable)
//
// one archive word per cycle while o_stall is low; parser state updates at the accept edge
// results are written at the accept edge into a FIFO_DEPTH-entry queue (4 by default) and leave it in order
// o_stall rises while fewer than two queue entries are free, since a header
// that completes on the final word gives two results
// reset is synchronous, active low; clears parser, queue and extract enable
module tar_stream_deframer
    import tsd_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = RES_FIFO_DEPTH
)(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_wr_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_archive_byte,
    input  logic              i_stream_end,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_kind,
    output logic [7:0]        o_data_out,
    output logic [SIZE_W-1:0] o_entry_size,
    output logic [7:0]        o_entry_type,
    output logic              o_is_regular,
    output logic              o_last_of_entry,
    output logic [1:0]        o_end_status
);

    logic    r_extract_enable;
    logic    in_accept;
    logic    full2;
    t_push   push;
    t_result res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_extract_enable <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_extract_enable <= i_cfg_wr_data;
        end
    end

    assign o_stall   = full2;
    assign in_accept = i_valid && !full2;

    tsd_parser u_parser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (in_accept),
        .i_archive_byte   (i_archive_byte),
        .i_stream_end     (i_stream_end),
        .i_extract_enable (r_extract_enable),
        .o_push           (push)
    );

    tsd_result_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (!i_stall),
        .o_valid (o_valid),
        .o_full2 (full2),
        .o_res   (res)
    );

    assign o_kind          = res.kind;
    assign o_data_out      = res.data_out;
    assign o_entry_size    = res.entry_size;
    assign o_entry_type    = res.entry_type;
    assign o_is_regular    = res.is_regular;
    assign o_last_of_entry = res.last_of_entry;
    assign o_end_status    = res.end_status;

endmodule
